@@ hdl/irwl_pkg.sv @@
// Shared types and constants for the infrared word link transceiver.
// Holds the command codes, register indexes, sync words and the state structs.
// No dependencies.
`timescale 1ns / 1ps

package irwl_pkg;

   localparam int unsigned MAX_WORD_BITS = 32;
   localparam int unsigned CNT_W         = 6;
   localparam int unsigned CSR_IDX_W     = 2;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_START = 2'd2
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] CSR_IS_SENDER    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_PERIOD = 2'd2;

   localparam logic [MAX_WORD_BITS-1:0] SYNC_FIRST  = 32'h0000_0000;
   localparam logic [MAX_WORD_BITS-1:0] SYNC_SECOND = 32'hAAAA_AAAA;
   localparam logic [MAX_WORD_BITS-1:0] SYNC_THIRD  = 32'hAE6C_B249;

   localparam logic [CNT_W-1:0] SYNC_LIMIT_RESET   = 6'd20;
   localparam logic [CNT_W-1:0] FRAME_PERIOD_RESET = 6'd15;
   localparam logic [CNT_W-1:0] CNT_MAX            = 6'd63;

   typedef struct packed {
      logic             is_sender_role;
      logic [CNT_W-1:0] sync_repeat_limit;
      logic [CNT_W-1:0] frame_period;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0] bit_position;
      logic             resting;
      logic             sample_delay;
      logic             link_up;
      logic             nearly_up;
      logic [CNT_W-1:0] sync_words_seen;
      logic [CNT_W-1:0] frame_counter;
      logic             ticking;
      logic             carrier;
      logic             led_high;
   } ctl_type;

   typedef struct packed {
      logic                     carrier_on;
      logic                     led_idle_high;
      logic [MAX_WORD_BITS-1:0] rx_word;
      logic                     rx_word_done;
      logic                     frame_tick;
      logic                     link_initialized;
      logic [CNT_W-1:0]         frame_count;
      logic                     awaiting_start;
   } rsp_type;

endpackage

@@ hdl/ir_word_link_transceiver.sv @@
// Infrared word link transceiver: takes one command word per clock while req_stall is
// low. A word is held in the input register and its results land in the result
// register when the word advances, which is also when the link state registers update.
// The result register frees while it is taken, so a new word enters while the
// previous result is still held; rsp_stall backs up into req_stall only when both
// stages are full. Configuration writes are always ready and must only be issued
// while no word is in flight. There is no clearing pass after reset. Depends on
// irwl_pkg, irwl_csr, irwl_step.
`timescale 1ns / 1ps

module ir_word_link_transceiver
   import irwl_pkg::*;
#(
   parameter int unsigned WORD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_command,
   input  logic                     req_rx_level_one,
   input  logic [MAX_WORD_BITS-1:0] req_tx_word_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_carrier_on,
   output logic                     rsp_led_idle_high,
   output logic [MAX_WORD_BITS-1:0] rsp_rx_word,
   output logic                     rsp_rx_word_done,
   output logic                     rsp_frame_tick,
   output logic                     rsp_link_initialized,
   output logic [CNT_W-1:0]         rsp_frame_count,
   output logic                     rsp_awaiting_start,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CNT_W-1:0]         csr_wdata
);

   cfg_type cfg;

   logic                 stage_v_ff, stage_v_in;
   logic [1:0]           cmd_ff;
   logic                 rxb_ff;
   logic [WORD_BITS-1:0] txw_ff;
   logic                 rsp_v_ff, rsp_v_in;
   rsp_type              rsp_ff, rsp_in;

   ctl_type              ctl_ff, ctl_in;
   logic [WORD_BITS-1:0] rx_shift_ff, rx_shift_in;
   logic [WORD_BITS-1:0] tx_hold_ff, tx_hold_in;
   logic                 word_done;
   logic                 frame_tick;

   logic accept_req;
   logic advance;

   irwl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   irwl_step #(
      .WORD_BITS (WORD_BITS)
   ) u_step (
      .cfg           (cfg),
      .ctl           (ctl_ff),
      .rx_shift      (rx_shift_ff),
      .tx_hold       (tx_hold_ff),
      .command       (cmd_ff),
      .rx_level_one  (rxb_ff),
      .tx_word       (txw_ff),
      .ctl_next      (ctl_in),
      .rx_shift_next (rx_shift_in),
      .tx_hold_next  (tx_hold_in),
      .word_done     (word_done),
      .frame_tick    (frame_tick)
   );

   // advance the held word whenever the result slot is empty or being taken
   assign advance    = stage_v_ff & (~rsp_v_ff | ~rsp_stall);
   assign req_stall  = stage_v_ff & ~advance;
   assign accept_req = req_valid & ~req_stall;
   assign stage_v_in = accept_req | (stage_v_ff & ~advance);
   assign rsp_v_in   = advance | (rsp_v_ff & rsp_stall);

   always_comb begin
      rsp_in.carrier_on       = ctl_in.carrier;
      rsp_in.led_idle_high    = ctl_in.led_high;
      rsp_in.rx_word          = MAX_WORD_BITS'(rx_shift_in);
      rsp_in.rx_word_done     = word_done;
      rsp_in.frame_tick       = frame_tick;
      rsp_in.link_initialized = ctl_in.link_up;
      rsp_in.frame_count      = ctl_in.frame_counter;
      rsp_in.awaiting_start   = ~ctl_in.ticking;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff  <= 1'b0;
         rsp_v_ff    <= 1'b0;
         ctl_ff      <= '0;
         rx_shift_ff <= '0;
         tx_hold_ff  <= '0;
      end else begin
         stage_v_ff <= stage_v_in;
         rsp_v_ff   <= rsp_v_in;
         if (advance) begin
            ctl_ff      <= ctl_in;
            rx_shift_ff <= rx_shift_in;
            tx_hold_ff  <= tx_hold_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_req) begin
         cmd_ff <= req_command;
         rxb_ff <= req_rx_level_one;
         txw_ff <= req_tx_word_in[WORD_BITS-1:0];
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid            = rsp_v_ff;
   assign rsp_carrier_on       = rsp_ff.carrier_on;
   assign rsp_led_idle_high    = rsp_ff.led_idle_high;
   assign rsp_rx_word          = rsp_ff.rx_word;
   assign rsp_rx_word_done     = rsp_ff.rx_word_done;
   assign rsp_frame_tick       = rsp_ff.frame_tick;
   assign rsp_link_initialized = rsp_ff.link_initialized;
   assign rsp_frame_count      = rsp_ff.frame_count;
   assign rsp_awaiting_start   = rsp_ff.awaiting_start;

   // a frame tick only comes with the end of a word
   a_tick_needs_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_tick) |-> rsp_rx_word_done)
      else $error("frame tick without word completion");

   // the bit counter never runs past the longest word with start burst and sample delay
   a_bitpos_bound: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.bit_position <= CNT_W'(WORD_BITS + 4))
      else $error("bit position out of range");

   // sync words are counted only after the second sync word was seen
   a_seen_needs_nearly: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff.sync_words_seen != '0) |-> ctl_ff.nearly_up)
      else $error("sync word count without nearly-up");

   // the state moves only when a word moves into the result register
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(ctl_ff))
      else $error("link state changed without a word");

endmodule

@@ hdl/irwl_csr.sv @@
// Configuration registers of the infrared word link transceiver.
// Depends on irwl_pkg for the register indexes and the cfg_type struct.
`timescale 1ns / 1ps

module irwl_csr
   import irwl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata,
   output logic                 csr_ready,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IS_SENDER:    cfg_in.is_sender_role    = csr_wdata[0];
            CSR_SYNC_LIMIT:   cfg_in.sync_repeat_limit = csr_wdata;
            CSR_FRAME_PERIOD: cfg_in.frame_period      = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.is_sender_role    <= 1'b1;
         cfg_ff.sync_repeat_limit <= SYNC_LIMIT_RESET;
         cfg_ff.frame_period      <= FRAME_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hdl/irwl_step.sv @@
// Next-state logic for one word: tick, load or start, plus the end-of-word sync handshake.
// Depends on irwl_pkg for the command codes, sync words and state structs.
`timescale 1ns / 1ps

module irwl_step
   import irwl_pkg::*;
#(
   parameter int unsigned WORD_BITS = 32
) (
   input  cfg_type              cfg,
   input  ctl_type              ctl,
   input  logic [WORD_BITS-1:0] rx_shift,
   input  logic [WORD_BITS-1:0] tx_hold,
   input  logic [1:0]           command,
   input  logic                 rx_level_one,
   input  logic [WORD_BITS-1:0] tx_word,
   output ctl_type              ctl_next,
   output logic [WORD_BITS-1:0] rx_shift_next,
   output logic [WORD_BITS-1:0] tx_hold_next,
   output logic                 word_done,
   output logic                 frame_tick
);

   localparam int unsigned IDX_W = $clog2(WORD_BITS);
   localparam logic [6:0] WB7 = 7'(WORD_BITS);
   localparam logic [WORD_BITS-1:0] SYNC_FIRST_W  = SYNC_FIRST[WORD_BITS-1:0];
   localparam logic [WORD_BITS-1:0] SYNC_SECOND_W = SYNC_SECOND[WORD_BITS-1:0];
   localparam logic [WORD_BITS-1:0] SYNC_THIRD_W  = SYNC_THIRD[WORD_BITS-1:0];

   logic             snd;
   logic [6:0]       idx7;
   logic [6:0]       off7;
   logic [6:0]       rel7;
   logic [6:0]       sh_rx7;
   logic [6:0]       sh_tx7;
   logic             finish;
   logic [6:0]       seen7;
   logic [CNT_W-1:0] frame_base;

   assign snd    = cfg.is_sender_role;
   assign idx7   = {1'b0, ctl.bit_position};
   assign off7   = {6'd0, ctl.sample_delay};
   assign rel7   = idx7 - off7;
   assign sh_rx7 = WB7 - rel7;
   assign sh_tx7 = WB7 - idx7;
   assign finish = idx7 > (WB7 + off7 + off7 + off7);

   always_comb begin
      ctl_next      = ctl;
      rx_shift_next = rx_shift;
      tx_hold_next  = tx_hold;
      word_done     = 1'b0;
      frame_tick    = 1'b0;
      seen7         = {1'b0, ctl.sync_words_seen};
      frame_base    = ctl.frame_counter;
      unique case (command)
         CMD_LOAD: begin
            tx_hold_next = tx_word;
         end
         CMD_START: begin
            ctl_next.bit_position = '0;
            ctl_next.ticking      = 1'b1;
            if (snd) begin
               ctl_next.sample_delay = 1'b1;
               tx_hold_next          = SYNC_FIRST_W;
            end else begin
               tx_hold_next = SYNC_SECOND_W;
            end
         end
         CMD_TICK: begin
            if (ctl.ticking && ctl.resting) begin
               ctl_next.carrier  = 1'b0;
               ctl_next.led_high = 1'b1;
               ctl_next.resting  = 1'b0;
            end else if (ctl.ticking) begin
               // start burst opens the word on the sender side
               if (ctl.bit_position == '0 && snd) begin
                  rx_shift_next    = '0;
                  ctl_next.carrier = 1'b1;
               end
               if (idx7 >= 7'd1 + off7 && rel7 <= WB7) begin
                  rx_shift_next[sh_rx7[IDX_W-1:0]] = rx_level_one;
               end
               if (idx7 >= 7'd1 && idx7 <= WB7) begin
                  if (tx_hold[sh_tx7[IDX_W-1:0]]) begin
                     ctl_next.carrier = 1'b1;
                  end else begin
                     ctl_next.carrier  = 1'b0;
                     ctl_next.led_high = 1'b0;
                  end
               end
               ctl_next.resting      = 1'b1;
               ctl_next.bit_position = ctl.bit_position + 1'b1;
               if (finish) begin
                  if (!ctl.link_up) begin
                     if (rx_shift_next == SYNC_SECOND_W) begin
                        if (snd) begin
                           tx_hold_next = SYNC_SECOND_W;
                        end else begin
                           tx_hold_next       = SYNC_THIRD_W;
                           ctl_next.nearly_up = 1'b1;
                        end
                     end
                     if (rx_shift_next == SYNC_THIRD_W && snd) begin
                        ctl_next.link_up = 1'b1;
                     end
                     if (ctl_next.nearly_up && !snd) begin
                        if (ctl.sync_words_seen <= cfg.sync_repeat_limit) begin
                           seen7 = {1'b0, ctl.sync_words_seen} + 7'd1;
                        end
                        if (seen7 > {1'b0, cfg.sync_repeat_limit}) begin
                           ctl_next.link_up = 1'b1;
                        end
                        ctl_next.sync_words_seen = (seen7 > {1'b0, CNT_MAX}) ? CNT_MAX
                                                                             : seen7[CNT_W-1:0];
                     end
                  end
                  if (ctl.frame_counter >= cfg.frame_period) begin
                     frame_tick = 1'b1;
                     frame_base = '0;
                  end
                  ctl_next.frame_counter = frame_base;
                  if (snd) begin
                     ctl_next.frame_counter = frame_base + 1'b1;
                  end else begin
                     ctl_next.ticking = 1'b0;
                  end
                  word_done             = 1'b1;
                  ctl_next.bit_position = '0;
               end
            end
         end
         default: begin
            ctl_next = ctl;
         end
      endcase
   end

endmodule
